// ===== rtl/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types, constants and value checks for the UTF-8 decoder core.
// ----------------------------------------------------------------------------
package utf8d_pkg;

   // field widths
   localparam int CpWidth    = 21;
   localparam int AccWidth   = 31;
   localparam int CountWidth = 3;
   localparam int TotalWidth = 32;
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;

   // register indexes on the configuration port
   localparam logic RegMaxCodePoint   = 1'b0;
   localparam logic RegReplacementChr = 1'b1;

   // register reset values
   localparam logic [CpWidth-1:0] MaxCodePointReset = 21'h10FFFF;
   localparam logic [CpWidth-1:0] ReplacementReset  = 21'h00FFFD;

   // special code points
   localparam logic [AccWidth-1:0] BomCp        = 31'h0000FEFF;
   localparam logic [AccWidth-1:0] SurrogateLo  = 31'h0000D800;
   localparam logic [AccWidth-1:0] SurrogateHi  = 31'h0000DFFF;
   localparam logic [AccWidth-1:0] NoncharLo    = 31'h0000FDD0;
   localparam logic [AccWidth-1:0] NoncharHi    = 31'h0000FDEF;

   // work left for the output side after one input item
   typedef struct packed {
      logic [CountWidth-1:0] reps;    // replacement results, sent first
      logic                  has_val; // one plain code point after them
      logic [CpWidth-1:0]    val;
   } plan_type;

   // smallest value allowed for a sequence with this many continuation bytes
   function automatic logic [AccWidth-1:0] min_value(input logic [CountWidth-1:0] need);
      logic [AccWidth-1:0] m;
      case (need)
         3'd1:    m = 31'h00000080;
         3'd2:    m = 31'h00000800;
         3'd3:    m = 31'h00010000;
         3'd4:    m = 31'h00200000;
         3'd5:    m = 31'h04000000;
         default: m = '0;
      endcase
      return m;
   endfunction

   // overlong, surrogate, noncharacter or above the configured maximum
   function automatic logic rejected(input logic [AccWidth-1:0]   v,
                                     input logic [CountWidth-1:0] need,
                                     input logic [CpWidth-1:0]    max_cp);
      logic bad;
      bad = (v < min_value(need))
         || ((v >= SurrogateLo) && (v <= SurrogateHi))
         || ((v >= NoncharLo) && ((v <= NoncharHi) || (v[15:1] == 15'h7FFF)))
         || (v > {{(AccWidth-CpWidth){1'b0}}, max_cp});
      return bad;
   endfunction

endpackage

// ===== rtl/utf8_to_code_point_decoder_core.sv =====
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder_core
// UTF-8 byte stream to code point decoder with replacement of invalid input.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/stall     data_byte
//   rsp      out        rsp_valid/stall     code_point, replaced, invalid_total,
//                                           last
//   csr      in         APB-style           max_code_point, replacement_char
//
// One byte is taken per cycle unless the input is held; a byte giving k results
// holds the input while the result register sends them one per cycle when the
// output is not stalled. A byte passes through the plan register, then the result
// register. Reset is synchronous and clears the control state of both registers;
// their payload fields are not reset. A stalled result holds in the result register
// while the next item's plan waits in the plan register.
// ----------------------------------------------------------------------------
module utf8_to_code_point_decoder_core
   import utf8d_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_data_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [CpWidth-1:0]      rsp_code_point,
   output logic                    rsp_replaced,
   output logic [TotalWidth-1:0]   rsp_invalid_total,
   output logic                    rsp_last,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   logic               accept;
   logic               plan_busy;
   logic [CpWidth-1:0] max_cp;
   logic [CpWidth-1:0] rep_char;
   plan_type           plan;

   assign req_stall = plan_busy;
   assign accept    = req_valid && !plan_busy;

   // configuration registers
   utf8d_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_cp      (max_cp),
      .rep_char    (rep_char)
   );

   // byte decode and sequence state
   utf8d_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .max_cp    (max_cp),
      .plan      (plan)
   );

   // result sequencing
   utf8d_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .plan              (plan),
      .rep_char          (rep_char),
      .plan_busy         (plan_busy),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_code_point    (rsp_code_point),
      .rsp_replaced      (rsp_replaced),
      .rsp_invalid_total (rsp_invalid_total),
      .rsp_last          (rsp_last)
   );

endmodule

// ===== rtl/utf8d_csr.sv =====
// ----------------------------------------------------------------------------
// utf8d_csr
// Configuration registers on an APB-style port: maximum code point and
// replacement character.
// ----------------------------------------------------------------------------
module utf8d_csr
   import utf8d_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready,
   output logic [CpWidth-1:0]      max_cp,
   output logic [CpWidth-1:0]      rep_char
);

   logic [CpWidth-1:0] max_cp_ff;
   logic [CpWidth-1:0] rep_char_ff;
   logic               wr_en;
   logic               reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   // word select; byte offset bits are ignored
   assign reg_sel    = csr_paddr[2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_cp_ff   <= MaxCodePointReset;
         rep_char_ff <= ReplacementReset;
      end else if (wr_en) begin
         if (reg_sel == RegMaxCodePoint) begin
            max_cp_ff <= csr_pwdata[CpWidth-1:0];
         end else begin
            rep_char_ff <= csr_pwdata[CpWidth-1:0];
         end
      end
   end

   // read back
   always_comb begin
      unique case (reg_sel)
         RegMaxCodePoint:   csr_prdata = {{(CsrDataWidth-CpWidth){1'b0}}, max_cp_ff};
         RegReplacementChr: csr_prdata = {{(CsrDataWidth-CpWidth){1'b0}}, rep_char_ff};
         default:           csr_prdata = '0;
      endcase
   end

   assign max_cp   = max_cp_ff;
   assign rep_char = rep_char_ff;

endmodule

// ===== rtl/utf8d_parse.sv =====
// ----------------------------------------------------------------------------
// utf8d_parse
// Sequence state and byte decode: turns each accepted byte into a plan of
// replacement results and an optional code point.
// ----------------------------------------------------------------------------
module utf8d_parse
   import utf8d_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         data_byte,
   input  logic [CpWidth-1:0] max_cp,
   output plan_type           plan
);

   logic [AccWidth-1:0]   acc_ff,  acc_in;
   logic [CountWidth-1:0] need_ff, need_in;
   logic [CountWidth-1:0] seen_ff, seen_in;
   logic [AccWidth-1:0]   shifted;
   logic [CountWidth-1:0] seen_inc;
   logic                  lead_go;
   plan_type              plan_c;

   assign shifted  = {acc_ff[AccWidth-7:0], data_byte[5:0]};
   assign seen_inc = seen_ff + 3'd1;

   // continuation handling, then fresh lead byte decode
   always_comb begin
      acc_in  = acc_ff;
      need_in = need_ff;
      seen_in = seen_ff;
      plan_c  = '0;
      lead_go = 1'b0;

      if (need_ff != '0) begin
         if (data_byte[7:6] == 2'b10) begin
            acc_in  = shifted;
            seen_in = seen_inc;
            if (seen_inc >= need_ff) begin
               acc_in  = '0;
               need_in = '0;
               seen_in = '0;
               if (shifted == BomCp) begin
                  plan_c = '0;
               end else if (rejected(shifted, need_ff, max_cp)) begin
                  plan_c.reps = need_ff + 3'd1;
               end else begin
                  plan_c.has_val = 1'b1;
                  plan_c.val     = shifted[CpWidth-1:0];
               end
            end
         end else begin
            // broken sequence: one replacement per byte so far
            plan_c.reps = seen_ff + 3'd1;
            acc_in      = '0;
            lead_go     = 1'b1;
         end
      end else begin
         lead_go = 1'b1;
      end

      if (lead_go) begin
         need_in = '0;
         seen_in = '0;
         if (data_byte[7] == 1'b0) begin
            plan_c.has_val = 1'b1;
            plan_c.val     = {{(CpWidth-8){1'b0}}, data_byte};
         end else if (data_byte[7:5] == 3'b110) begin
            acc_in  = {{(AccWidth-5){1'b0}}, data_byte[4:0]};
            need_in = 3'd1;
         end else if (data_byte[7:4] == 4'b1110) begin
            acc_in  = {{(AccWidth-4){1'b0}}, data_byte[3:0]};
            need_in = 3'd2;
         end else if (data_byte[7:3] == 5'b11110) begin
            acc_in  = {{(AccWidth-3){1'b0}}, data_byte[2:0]};
            need_in = 3'd3;
         end else if (data_byte[7:2] == 6'b111110) begin
            acc_in  = {{(AccWidth-2){1'b0}}, data_byte[1:0]};
            need_in = 3'd4;
         end else if (data_byte[7:1] == 7'b1111110) begin
            acc_in  = {{(AccWidth-1){1'b0}}, data_byte[0]};
            need_in = 3'd5;
         end else begin
            // stray continuation or 0xFE / 0xFF
            plan_c.reps = plan_c.reps + 3'd1;
         end
      end
   end

   // state update on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         need_ff <= '0;
         seen_ff <= '0;
      end else if (accept) begin
         acc_ff  <= acc_in;
         need_ff <= need_in;
         seen_ff <= seen_in;
      end
   end

   assign plan = plan_c;

endmodule

// ===== rtl/utf8d_emit.sv =====
// ----------------------------------------------------------------------------
// utf8d_emit
// Plan register and result register: sends the results of one item one per
// cycle unless stalled and keeps the saturating replacement count.
// ----------------------------------------------------------------------------
module utf8d_emit
   import utf8d_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  plan_type              plan,
   input  logic [CpWidth-1:0]    rep_char,
   output logic                  plan_busy,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CpWidth-1:0]    rsp_code_point,
   output logic                  rsp_replaced,
   output logic [TotalWidth-1:0] rsp_invalid_total,
   output logic                  rsp_last
);

   logic [CountWidth-1:0] reps_ff,  reps_in;
   logic                  hval_ff,  hval_in;
   logic [CpWidth-1:0]    val_ff;
   logic [TotalWidth-1:0] cnt_ff,   cnt_in;
   logic                  out_vld_ff, out_vld_in;
   logic [CpWidth-1:0]    out_cp_ff;
   logic                  out_rep_ff;
   logic [TotalWidth-1:0] out_tot_ff;
   logic                  out_last_ff;
   logic                  out_free;
   logic                  pend_empty;
   logic                  pend_single;
   logic                  emit;
   logic                  emit_rep;

   assign out_free    = !out_vld_ff || !rsp_stall;
   assign pend_empty  = (reps_ff == '0) && !hval_ff;
   assign pend_single = ((reps_ff == 3'd1) && !hval_ff) || ((reps_ff == '0) && hval_ff);
   assign emit        = out_free && !pend_empty;
   assign emit_rep    = reps_ff != '0;

   // input open once the plan register drains this cycle
   assign plan_busy = !(pend_empty || (pend_single && out_free));

   // next plan and counter
   always_comb begin
      reps_in    = reps_ff;
      hval_in    = hval_ff;
      cnt_in     = cnt_ff;
      out_vld_in = out_vld_ff;
      if (out_free) begin
         out_vld_in = emit;
      end
      if (emit) begin
         if (emit_rep) begin
            reps_in = reps_ff - 3'd1;
            if (cnt_ff != '1) begin
               cnt_in = cnt_ff + 32'd1;
            end
         end else begin
            hval_in = 1'b0;
         end
      end
      if (accept) begin
         reps_in = plan.reps;
         hval_in = plan.has_val;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reps_ff    <= '0;
         hval_ff    <= 1'b0;
         cnt_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         reps_ff    <= reps_in;
         hval_ff    <= hval_in;
         cnt_ff     <= cnt_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         val_ff <= plan.val;
      end
      if (emit) begin
         out_cp_ff   <= emit_rep ? rep_char : val_ff;
         out_rep_ff  <= emit_rep;
         out_tot_ff  <= cnt_in;
         out_last_ff <= pend_single;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_code_point    = out_cp_ff;
   assign rsp_replaced      = out_rep_ff;
   assign rsp_invalid_total = out_tot_ff;
   assign rsp_last          = out_last_ff;

   // an empty plan register never holds off the input
   a_open_when_empty: assert property (@(posedge clock) disable iff (reset)
      pend_empty |-> !plan_busy)
      else $error("input held off with no pending results");

   // a plain code point is always the final result of its item
   a_value_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !out_rep_ff) |-> out_last_ff)
      else $error("plain result not marked last");

   // replacement count never goes down
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (cnt_ff >= $past(cnt_ff)))
      else $error("replacement count decreased");

   // a replacement result carries a nonzero running total
   a_rep_counted: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_rep_ff) |-> (out_tot_ff != '0))
      else $error("replacement without count");

endmodule
